### src/assert_macros.svh
// Assertion macros shared by the convolution engine RTL.
// Included by the top level; empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/cnv_pkg.sv
// Package for the 3x3 convolution engine: opcodes, status codes, FSM state,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package cnv_pkg;
  localparam int unsigned TAPS = 9;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned ACC_W = 48;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_SOURCE = 2'd2,
    OP_COMPUTE     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SATURATED = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_OUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_bias;   // acc <= bias * 2^14 (bias read data valid)
    logic issue;       // issue memory reads at current counters
    logic clear_cnt;   // reset channel/tap counters
    logic mac_en;      // product stage valid flows into accumulator
    logic round_en;    // round, saturate, rectify into result register
    logic set_outside; // result register <= 0, status outside
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last_issue;  // current counters address the final tap
    logic pipe_empty;  // no MAC in flight
    logic no_channels; // channel count is zero
  } dp_stat_t;
endpackage

### src/cnv_ctrl.sv
// Controller FSM for the convolution engine: sequences bias load, the
// channel/tap MAC walk, pipeline drain, rounding and result hand-off.
// Depends on cnv_pkg.
`timescale 1ns / 1ps
module cnv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              outside,
  input  logic              out_taken,
  input  cnv_pkg::dp_stat_t stat,
  output cnv_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import cnv_pkg::*;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        cmd.clear_cnt = 1'b1;
        if (start) begin
          if (outside) begin
            cmd.set_outside = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_BIAS;
          end
        end
      end
      S_BIAS: begin
        cmd.load_bias = 1'b1;
        state_nxt = stat.no_channels ? S_DRAIN : S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        cmd.mac_en = 1'b1;
        if (stat.last_issue) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.mac_en = 1'b1;
        if (stat.pipe_empty) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### src/cnv_datapath.sv
// Datapath of the convolution engine: weight, bias and source memories,
// address counters, one registered MAC into a 48-bit accumulator, rounding.
// Depends on cnv_pkg.
`timescale 1ns / 1ps
module cnv_datapath #(
  parameter int unsigned MAX_INPUT_CHANNELS = 64,
  parameter int unsigned OUTPUT_CHANNELS    = 64,
  parameter int unsigned TILE_WIDTH         = 32,
  parameter int unsigned TILE_HEIGHT        = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cnv_pkg::dp_cmd_t  cmd,
  output cnv_pkg::dp_stat_t stat,
  // load port
  input  logic              ld_en,
  input  logic [1:0]        ld_op,
  input  logic [5:0]        ld_oc,
  input  logic [5:0]        ld_ic,
  input  logic [4:0]        ld_row,
  input  logic [4:0]        ld_col,
  input  logic [3:0]        ld_tap,
  input  logic [15:0]       ld_val,
  // compute job
  input  logic              start,
  input  logic [6:0]        chan_count,
  output logic [14:0]       res_value,
  output logic [1:0]        res_status
);
  import cnv_pkg::*;

  localparam int unsigned OCW = (OUTPUT_CHANNELS > 1) ? $clog2(OUTPUT_CHANNELS) : 1;
  localparam int unsigned CNW = $clog2(MAX_INPUT_CHANNELS + 1);
  localparam int unsigned RW  = $clog2(TILE_HEIGHT);
  localparam int unsigned CW  = $clog2(TILE_WIDTH);
  localparam int unsigned WDEPTH = OUTPUT_CHANNELS * MAX_INPUT_CHANNELS * TAPS;
  localparam int unsigned SDEPTH = MAX_INPUT_CHANNELS * TILE_HEIGHT * TILE_WIDTH;
  localparam int unsigned WAW = $clog2(WDEPTH);
  localparam int unsigned SAW = $clog2(SDEPTH);
  localparam int unsigned PW  = 32;

  logic [VAL_W-1:0] weight_mem [WDEPTH];
  logic [VAL_W-1:0] source_mem [SDEPTH];
  logic [VAL_W-1:0] bias_mem   [OUTPUT_CHANNELS];

  // Load address decode (wide compares so any parameter range works)
  logic w_ok, b_ok, s_ok;
  logic [WAW-1:0] w_waddr;
  logic [SAW-1:0] s_waddr;
  assign w_ok = (32'(ld_oc) < OUTPUT_CHANNELS) && (32'(ld_ic) < MAX_INPUT_CHANNELS)
              && (32'(ld_tap) < TAPS);
  assign b_ok = 32'(ld_oc) < OUTPUT_CHANNELS;
  assign s_ok = (32'(ld_ic) < MAX_INPUT_CHANNELS) && (32'(ld_row) < TILE_HEIGHT)
              && (32'(ld_col) < TILE_WIDTH);
  assign w_waddr = WAW'((32'(ld_oc) * MAX_INPUT_CHANNELS + 32'(ld_ic)) * TAPS + 32'(ld_tap));
  assign s_waddr = SAW'((32'(ld_ic) * TILE_HEIGHT + 32'(ld_row)) * TILE_WIDTH + 32'(ld_col));

  // Job registers: channel, base position, channel count
  logic [OCW-1:0] oc_r;
  logic [RW-1:0]  row_r;
  logic [CW-1:0]  col_r;
  logic [CNW-1:0] n_r;
  logic [CNW-1:0] c_r;
  logic [3:0]     t_r;
  logic [1:0]     kr_r, kc_r;
  logic [WAW-1:0] wa_r;

  always_ff @(posedge clk) begin
    if (start) begin
      oc_r  <= OCW'(ld_oc);
      row_r <= RW'(ld_row);
      col_r <= CW'(ld_col);
      n_r   <= (32'(chan_count) > MAX_INPUT_CHANNELS) ? CNW'(MAX_INPUT_CHANNELS)
                                                     : CNW'(chan_count);
    end
  end

  // Advance channel/tap counters; weight address runs linearly
  always_ff @(posedge clk) begin
    if (cmd.clear_cnt) begin
      c_r <= '0; t_r <= '0; kr_r <= '0; kc_r <= '0;
    end else if (cmd.issue) begin
      if (t_r == 4'(TAPS - 1)) begin
        t_r <= '0; kr_r <= '0; kc_r <= '0; c_r <= c_r + 1'b1;
      end else begin
        t_r <= t_r + 1'b1;
        if (kc_r == 2'd2) begin
          kc_r <= '0; kr_r <= kr_r + 1'b1;
        end else begin
          kc_r <= kc_r + 1'b1;
        end
      end
    end
    if (cmd.load_bias) wa_r <= WAW'(32'(oc_r) * MAX_INPUT_CHANNELS * TAPS);
    else if (cmd.issue) wa_r <= wa_r + 1'b1;
  end

  logic [SAW-1:0] s_raddr;
  assign s_raddr = SAW'((32'(c_r) * TILE_HEIGHT + 32'(row_r) + 32'(kr_r)) * TILE_WIDTH
                        + 32'(col_r) + 32'(kc_r));

  assign stat.last_issue  = (t_r == 4'(TAPS - 1)) && (c_r == n_r - 1'b1);
  assign stat.no_channels = (n_r == '0);

  // Memories: write on load, registered read
  logic [VAL_W-1:0] w_rd_r, s_rd_r, b_rd_r;
  always_ff @(posedge clk) begin
    if (ld_en && ld_op == OP_LOAD_WEIGHT && w_ok) weight_mem[w_waddr] <= ld_val;
    w_rd_r <= weight_mem[wa_r];
  end
  always_ff @(posedge clk) begin
    if (ld_en && ld_op == OP_LOAD_SOURCE && s_ok) source_mem[s_waddr] <= ld_val;
    s_rd_r <= source_mem[s_raddr];
  end
  // Read the bias of the incoming item so it is ready in the bias cycle
  always_ff @(posedge clk) begin
    if (ld_en && ld_op == OP_LOAD_BIAS && b_ok) bias_mem[OCW'(ld_oc)] <= ld_val;
    b_rd_r <= bias_mem[start ? OCW'(ld_oc) : oc_r];
  end

  // Pipeline valids: read stage, product stage
  logic rd_v_r, prod_v_r;
  logic signed [PW-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0; prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
    end
  end
  always_ff @(posedge clk) begin
    prod_r <= $signed(s_rd_r) * $signed(w_rd_r);
  end
  assign stat.pipe_empty = !rd_v_r && !prod_v_r;

  // Accumulate
  logic signed [ACC_W-1:0] acc_r;
  always_ff @(posedge clk) begin
    if (cmd.load_bias) acc_r <= ACC_W'($signed(b_rd_r)) <<< 14;
    else if (cmd.mac_en && prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  // Round half up, saturate, rectify
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-15:0] q;
  assign rnd = acc_r + ACC_W'(8192);
  assign q   = rnd[ACC_W-1:14];
  logic [14:0] val_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    if (cmd.set_outside) begin
      val_r <= '0; st_r <= ST_OUTSIDE;
    end else if (cmd.round_en) begin
      if (q > $signed((ACC_W-14)'(32767))) begin
        val_r <= 15'h7FFF; st_r <= ST_SATURATED;
      end else if (q < -$signed((ACC_W-14)'(32768))) begin
        val_r <= '0; st_r <= ST_SATURATED;
      end else begin
        val_r <= q[ACC_W-15] ? 15'd0 : q[14:0];
        st_r  <= ST_OK;
      end
    end
  end
  assign res_value  = val_r;
  assign res_status = st_r;
endmodule

### src/conv3x3_bias_relu_engine_top.sv
// Top level of the 3x3 valid convolution engine with bias and ReLU.
// Depends on cnv_pkg, cnv_ctrl, cnv_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Load items (weight, bias, source sample) are taken while the engine is
// idle or a result waits. A compute item runs on a single
// multiply-accumulate unit: a bias read, then MAC issue over channels x 9
// taps (one weight and one source read per cycle), pipeline drain, a round
// step, and the result is held in the output register until taken.
// Positions outside the output plane answer in the next cycle. The block
// handles one compute item at a time; while a result waits, load items are
// still taken but a compute item is held. Memories need no clearing after
// reset.
module conv3x3_bias_relu_engine_top #(
  parameter int unsigned MAX_INPUT_CHANNELS = 64,
  parameter int unsigned OUTPUT_CHANNELS    = 64,
  parameter int unsigned TILE_WIDTH         = 32,
  parameter int unsigned TILE_HEIGHT        = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_output_channel,
  input  logic [5:0]  in_input_channel,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_column,
  input  logic [3:0]  in_tap,
  input  logic signed [15:0] in_load_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_out_value,
  output logic [1:0]  out_status
);
  import cnv_pkg::*;

  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  logic [6:0] chan_r;
  logic [5:0] width_r, height_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 7'd64; width_r <= 6'd32; height_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNELS: chan_r <= cfg_data;
        CFG_WIDTH:    width_r <= cfg_data[5:0];
        CFG_HEIGHT:   height_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic busy, accept, start, outside;
  logic [10:0] w_eff, h_eff;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Take loads while a result waits; hold compute items until it is gone
  assign in_stall = out_valid ? (in_opcode == OP_COMPUTE) : busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_opcode == OP_COMPUTE);

  // Output plane check with tile sizes clamped to the parameters
  assign w_eff = (32'(width_r) > TILE_WIDTH) ? 11'(TILE_WIDTH) : 11'(width_r);
  assign h_eff = (32'(height_r) > TILE_HEIGHT) ? 11'(TILE_HEIGHT) : 11'(height_r);
  assign outside = (32'(in_output_channel) >= OUTPUT_CHANNELS)
                || (11'(in_row) + 11'd2 >= h_eff)
                || (11'(in_column) + 11'd2 >= w_eff);

  cnv_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .outside(outside),
    .out_taken(!out_stall), .stat(stat), .cmd(cmd), .busy(busy),
    .out_valid(out_valid)
  );

  cnv_datapath #(
    .MAX_INPUT_CHANNELS(MAX_INPUT_CHANNELS), .OUTPUT_CHANNELS(OUTPUT_CHANNELS),
    .TILE_WIDTH(TILE_WIDTH), .TILE_HEIGHT(TILE_HEIGHT)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .ld_en(accept), .ld_op(in_opcode), .ld_oc(in_output_channel),
    .ld_ic(in_input_channel), .ld_row(in_row), .ld_col(in_column),
    .ld_tap(in_tap), .ld_val(in_load_value), .start(start),
    .chan_count(chan_r), .res_value(out_out_value), .res_status(out_status)
  );

  `ASSERT_IMPLY(a_out_busy, clk, rst_n, out_valid, busy)
  `ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy)
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_valid, out_status <= ST_OUTSIDE)
  `ASSERT_IMPLY(a_sat_value, clk, rst_n, out_valid && out_status == ST_SATURATED, out_out_value == 15'h7FFF || out_out_value == 15'd0)
endmodule

### test/testbench.sv
// Self-checking testbench for conv3x3_bias_relu_engine_top: loads, computes, register sweeps.
// Depends on cnv_pkg and the engine RTL; predicts every output sample internally.
`timescale 1ns / 1ps
module testbench;
  import cnv_pkg::*;

  localparam int unsigned MAX_IC = 64;
  localparam int unsigned OUT_CH = 64;
  localparam int unsigned TW = 32;
  localparam int unsigned TH = 32;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned SETTLE = 30;

  // register indexes
  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;

  typedef struct {
    logic [14:0] value;
    status_t     status;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_output_channel = '0;
  logic [5:0] in_input_channel = '0;
  logic [4:0] in_row = '0;
  logic [4:0] in_column = '0;
  logic [3:0] in_tap = '0;
  logic signed [15:0] in_load_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_out_value;
  logic [1:0] out_status;

  conv3x3_bias_relu_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_output_channel(in_output_channel),
    .in_input_channel(in_input_channel), .in_row(in_row), .in_column(in_column),
    .in_tap(in_tap), .in_load_value(in_load_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_value(out_out_value), .out_status(out_status)
  );

  // Mirror of the engine state
  logic [15:0] weight_mem [MAX_IC*OUT_CH*9];
  bit          weight_set [MAX_IC*OUT_CH*9];
  logic [15:0] bias_mem [OUT_CH];
  bit          bias_set [OUT_CH];
  logic [15:0] tile_mem [MAX_IC*TH*TW];
  bit          tile_set [MAX_IC*TH*TW];
  logic [6:0] channel_count = 7'd64;
  logic [5:0] tile_width = 6'd32;
  logic [5:0] tile_height = 6'd32;

  sample_t pending_samples[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("conv3x3_bias_relu_engine_top: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned eff_width();
    return (tile_width > TW) ? TW : tile_width;
  endfunction
  function automatic int unsigned eff_height();
    return (tile_height > TH) ? TH : tile_height;
  endfunction
  function automatic int unsigned eff_channels();
    return (channel_count > MAX_IC) ? MAX_IC : channel_count;
  endfunction

  function automatic int unsigned weight_addr(int unsigned oc, int unsigned ic, int unsigned t);
    return (oc * MAX_IC + ic) * 9 + t;
  endfunction
  function automatic int unsigned tile_addr(int unsigned ic, int unsigned r, int unsigned c);
    return (ic * TH + r) * TW + c;
  endfunction

  // Convolve one output sample from the mirrored stores
  function automatic sample_t conv_sample(int unsigned oc, int unsigned r, int unsigned c);
    sample_t s;
    longint acc;
    longint rnd;
    s.value = '0;
    s.status = ST_OK;
    if (oc >= OUT_CH || r + 2 >= eff_height() || c + 2 >= eff_width()) begin
      s.status = ST_OUTSIDE;
      return s;
    end
    acc = longint'($signed(bias_mem[oc])) * 16384;
    for (int unsigned ic = 0; ic < eff_channels(); ic++)
      for (int unsigned t = 0; t < 9; t++)
        acc += longint'($signed(tile_mem[tile_addr(ic, r + t / 3, c + t % 3)])) *
               longint'($signed(weight_mem[weight_addr(oc, ic, t)]));
    rnd = (acc + 8192) >>> 14;
    if (rnd > 32767) begin
      rnd = 32767;
      s.status = ST_SATURATED;
    end else if (rnd < -32768) begin
      rnd = -32768;
      s.status = ST_SATURATED;
    end
    if (rnd < 0) rnd = 0;
    s.value = rnd[14:0];
    return s;
  endfunction

  // Apply one accepted item to the mirror
  task automatic apply_item(input opcode_t op, input int unsigned oc, input int unsigned ic,
                            input int unsigned r, input int unsigned c, input int unsigned t,
                            input logic [15:0] v);
    case (op)
      OP_LOAD_WEIGHT: begin
        if (t < 9) begin
          weight_mem[weight_addr(oc, ic, t)] = v;
          weight_set[weight_addr(oc, ic, t)] = 1'b1;
        end
      end
      OP_LOAD_BIAS: begin
        bias_mem[oc] = v;
        bias_set[oc] = 1'b1;
      end
      OP_LOAD_SOURCE: begin
        tile_mem[tile_addr(ic, r, c)] = v;
        tile_set[tile_addr(ic, r, c)] = 1'b1;
      end
      default: pending_samples.push_back(conv_sample(oc, r, c));
    endcase
  endtask

  // Send one item, with random idle cycles in front
  task automatic send_item(input opcode_t op, input int unsigned oc, input int unsigned ic,
                           input int unsigned r, input int unsigned c, input int unsigned t,
                           input logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_output_channel <= oc[5:0];
    in_input_channel <= ic[5:0];
    in_row <= r[4:0];
    in_column <= c[4:0];
    in_tap <= t[3:0];
    in_load_value <= v;
    do @(posedge clk); while (in_stall);
    apply_item(op, oc, ic, r, c, t, v);
  endtask

  function automatic logic [15:0] rand_value();
    if ($urandom_range(1)) return 16'($urandom_range(65535));
    return 16'($urandom_range(512) - 256);
  endfunction

  // Load every store entry a compute will read that is still unwritten
  task automatic fill_for_compute(input int unsigned oc, input int unsigned r,
                                  input int unsigned c);
    if (r + 2 >= eff_height() || c + 2 >= eff_width()) return;
    if (!bias_set[oc]) send_item(OP_LOAD_BIAS, oc, 0, 0, 0, 0, rand_value());
    for (int unsigned ic = 0; ic < eff_channels(); ic++)
      for (int unsigned t = 0; t < 9; t++) begin
        if (!weight_set[weight_addr(oc, ic, t)])
          send_item(OP_LOAD_WEIGHT, oc, ic, 0, 0, t, rand_value());
        if (!tile_set[tile_addr(ic, r + t / 3, c + t % 3)])
          send_item(OP_LOAD_SOURCE, 0, ic, r + t / 3, c + t % 3, 0, rand_value());
      end
  endtask

  task automatic compute_at(input int unsigned oc, input int unsigned r, input int unsigned c);
    fill_for_compute(oc, r, c);
    send_item(OP_COMPUTE, oc, $urandom_range(63), r, c, $urandom_range(15), rand_value());
  endtask

  // Hold the sender until every output sample is back, then let the engine settle
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNELS: channel_count = data;
      REG_WIDTH:    tile_width = data[5:0];
      default:      tile_height = data[5:0];
    endcase
  endtask

  task automatic set_geometry(input logic [6:0] n, input logic [6:0] w, input logic [6:0] h);
    drain_outputs();
    write_reg(REG_CHANNELS, n);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Receiver: random stall, compare each taken sample with the oldest prediction
  always @(posedge clk) begin
    sample_t want;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected output sample");
      end else begin
        want = pending_samples.pop_front();
        if (out_out_value !== want.value)
          report_mismatch($sformatf("out_value %0d, predicted %0d", out_out_value, want.value));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
      end
    end
  end

  // Reset-time geometry: full 64-channel sum over a 32x32 tile, plus plane edges
  task automatic test_reset_defaults();
    compute_at(5, 0, 0);
    compute_at(5, 30, 0);
    compute_at(5, 0, 30);
  endtask

  // Directed extremes and special cases
  task automatic test_directed();
    set_geometry(7'd1, 7'd3, 7'd3);
    send_item(OP_LOAD_BIAS, 1, 0, 0, 0, 0, 16'h0100);
    for (int unsigned t = 0; t < 9; t++) begin
      send_item(OP_LOAD_WEIGHT, 1, 0, 0, 0, t, 16'h7FFF);
      send_item(OP_LOAD_SOURCE, 0, 0, t / 3, t % 3, 0, 16'h7FFF);
    end
    compute_at(1, 0, 0);                                   // positive saturation
    send_item(OP_LOAD_WEIGHT, 1, 0, 0, 0, 15, 16'h1234);   // tap out of range, dropped
    send_item(OP_LOAD_WEIGHT, 1, 0, 0, 0, 4, 16'h8000);
    for (int unsigned t = 0; t < 9; t++)
      if (t != 4) send_item(OP_LOAD_WEIGHT, 1, 0, 0, 0, t, 16'h0000);
    compute_at(1, 0, 0);                                   // large negative, clamped at zero
    send_item(OP_LOAD_WEIGHT, 1, 0, 0, 0, 4, 16'h0001);
    send_item(OP_LOAD_SOURCE, 0, 0, 1, 1, 0, 16'h2000);
    compute_at(1, 0, 0);                                   // rounding half up
    compute_at(1, 1, 0);                                   // outside the output plane
    compute_at(1, 31, 31);
    set_geometry(7'd0, 7'd3, 7'd3);
    compute_at(1, 0, 0);                                   // zero channels: bias only
    send_item(OP_LOAD_BIAS, 1, 0, 0, 0, 0, 16'h8000);
    compute_at(1, 0, 0);
  endtask

  // Random items over several register settings and idle profiles
  task automatic test_random();
    logic [6:0] geo [8][3] = '{
      '{7'd4, 7'd32, 7'd32}, '{7'd1, 7'd3, 7'd3}, '{7'd2, 7'd8, 7'd6},
      '{7'd127, 7'd3, 7'd3}, '{7'd3, 7'd63, 7'd40}, '{7'd8, 7'd0, 7'd2},
      '{7'd6, 7'd12, 7'd20}, '{7'd64, 7'd3, 7'd3}};
    int unsigned sidle [3] = '{33, 51, 0};
    int unsigned ridle [3] = '{51, 33, 0};
    int unsigned count;
    int unsigned r;
    int unsigned c;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = sidle[mode];
      recv_idle_pct = ridle[mode];
      for (int g = 0; g < 8; g++) begin
        set_geometry(geo[g][0], geo[g][1], geo[g][2]);
        count = (eff_channels() >= 32) ? 4 : 12;
        for (int unsigned i = 0; i < count; i++) begin
          if (mode == 1 && g == 3 && i == count / 2) drain_outputs();
          case ($urandom_range(9))
            0, 1: send_item(OP_LOAD_WEIGHT, $urandom_range(63), $urandom_range(63), 0, 0,
                            $urandom_range(15), rand_value());
            2:    send_item(OP_LOAD_BIAS, $urandom_range(63), $urandom_range(63),
                            $urandom_range(31), $urandom_range(31), 0, rand_value());
            3, 4: send_item(OP_LOAD_SOURCE, $urandom_range(63), $urandom_range(63),
                            $urandom_range(31), $urandom_range(31), 0, rand_value());
            default: begin
              // Keep in-plane computes near the origin to bound the store fills
              if ($urandom_range(4) != 0 && eff_height() > 2 && eff_width() > 2) begin
                r = $urandom_range((eff_height() > 4) ? 1 : eff_height() - 3);
                c = $urandom_range((eff_width() > 4) ? 1 : eff_width() - 3);
              end else begin
                r = $urandom_range(31);
                c = $urandom_range(31);
              end
              compute_at((eff_channels() >= 32) ? 5 : $urandom_range(1), r, c);
            end
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    drain_outputs();
    if (error_count == 0)
      $display("conv3x3_bias_relu_engine_top: match");
    else
      $display("conv3x3_bias_relu_engine_top: mismatch");
    $finish;
  end
endmodule
